// File: rtl/dirty_tile_detector_defines.svh
// Assertion macros shared by the dirty tile detector RTL.
`ifndef DIRTY_TILE_DETECTOR_DEFINES_SVH
`define DIRTY_TILE_DETECTOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent.
`define DTD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dirty tile detector check failed");

// Consequent must hold in the cycle after the antecedent.
`define DTD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dirty tile detector check failed");

`else

`define DTD_ASSERT_SAME(label, clk, rst, ante, cons)
`define DTD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/dtd_pkg.sv
// Package with constants and types of the dirty tile detector.
`timescale 1ns / 1ps

package dtd_pkg;

   localparam int MAX_TILES   = 32;
   localparam int COORD_BITS  = 10;
   localparam int TC_BITS     = $clog2(MAX_TILES + 1);
   localparam int PIXEL_BITS  = 16;
   localparam int DIRTY_BITS  = 32;
   localparam int BAND_BITS   = 5;
   localparam int TOTAL_BITS  = 11;
   localparam int CSR_DATA_BITS = 10;
   localparam int REQ_DATA_BITS = 2 * PIXEL_BITS;
   localparam int RSP_DATA_BITS = BAND_BITS + DIRTY_BITS + TOTAL_BITS;

   typedef logic [COORD_BITS-1:0]    coord_type;
   typedef logic [COORD_BITS:0]      coord_wide_type;
   typedef logic [TC_BITS-1:0]       tcount_type;
   typedef logic [DIRTY_BITS-1:0]    bitmap_type;
   typedef logic [TOTAL_BITS-1:0]    total_type;
   typedef logic [PIXEL_BITS-1:0]    pixel_type;

   typedef enum logic [1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_TILE_WIDTH   = 2'd2,
      CSR_TILE_HEIGHT  = 2'd3
   } csr_index_type;

   localparam coord_type FRAME_WIDTH_RST  = coord_type'(320);
   localparam coord_type FRAME_HEIGHT_RST = coord_type'(240);
   localparam coord_type TILE_WIDTH_RST   = coord_type'(64);
   localparam coord_type TILE_HEIGHT_RST  = coord_type'(48);

   // A size register of zero behaves as one.
   function automatic coord_wide_type at_least_one(input coord_type v);
      coord_wide_type r;
      r = (v == '0) ? coord_wide_type'(1) : {1'b0, v};
      return r;
   endfunction

endpackage

// File: rtl/dirty_tile_detector.sv
// Top level of the dirty tile detector: per-band tile change bitmaps from a pixel stream.
`timescale 1ns / 1ps
`include "dirty_tile_detector_defines.svh"

// Channel | Direction | Transfer when            | Content
// req     | in        | req_tvalid & req_tready  | new/old pixel pair, first-of-frame flag
// rsp     | out       | rsp_tvalid & rsp_tready  | band bitmap, dirty count, frame end
// csr     | in        | csr_valid & csr_ready    | register index and 10-bit value
//
// One pixel is taken every cycle unless the input register is full and the result
// register is stalled; a pixel passes the input register and, at a band end, its
// band result is then loaded into the result register. The single comparison/counter update
// between those registers sets the rate.
// Synchronous active-high reset clears counters, bitmap, count and loads the
// default frame and tile sizes. A stalled result holds; input is still taken
// while the input register is empty or moves on, and waits while it is full
// and the result register is stalled.

module dirty_tile_detector
   import dtd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // req_tdata: new_pixel [15:0], old_pixel [31:16]
   input  logic [REQ_DATA_BITS-1:0]   req_tdata,
   // req_tuser: first_of_frame
   input  logic                       req_tuser,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // rsp_tdata: band_index [4:0], dirty_bits [36:5], changed_tiles [47:37]
   output logic [RSP_DATA_BITS-1:0]   rsp_tdata,
   // rsp_tlast: frame_done
   output logic                       rsp_tlast,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [1:0]                 csr_index,
   input  logic [CSR_DATA_BITS-1:0]   csr_data,
   input  logic                       csr_valid,
   output logic                       csr_ready
);

   // configuration registers
   coord_type frame_width_ff, frame_height_ff, tile_width_ff, tile_height_ff;

   // input register
   logic      s1_valid_ff, s1_valid_in;
   pixel_type s1_new_ff, s1_old_ff;
   logic      s1_first_ff;

   // frame state
   coord_type  column_pos_ff, column_pos_in;
   coord_type  column_in_tile_ff, column_in_tile_in;
   tcount_type tile_column_ff, tile_column_in;
   coord_type  line_pos_ff, line_pos_in;
   coord_type  line_in_tile_ff, line_in_tile_in;
   tcount_type band_count_ff, band_count_in;
   bitmap_type band_bitmap_ff, band_bitmap_in;
   total_type  dirty_total_ff, dirty_total_in;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff;
   logic                     rsp_last_ff;

   // working values
   logic       s1_adv, s1_fire;
   coord_type  cur_col, cur_cit, cur_line, cur_lit;
   tcount_type cur_tc, cur_bc;
   bitmap_type cur_bm, bit_mask, upd_bm;
   total_type  cur_total, upd_total;
   logic       pix_dirty, last_col, last_line, tile_col_end, band_end, emit, band_ok;
   logic [RSP_DATA_BITS-1:0] emit_data;

   // check terms
   logic       band_past_limit, emit_fire, frame_end_fire, frame_cleared;

   assign csr_ready = 1'b1;

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
         tile_width_ff   <= TILE_WIDTH_RST;
         tile_height_ff  <= TILE_HEIGHT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:  frame_width_ff  <= coord_type'(csr_data);
            CSR_FRAME_HEIGHT: frame_height_ff <= coord_type'(csr_data);
            CSR_TILE_WIDTH:   tile_width_ff   <= coord_type'(csr_data);
            CSR_TILE_HEIGHT:  tile_height_ff  <= coord_type'(csr_data);
            default: ;
         endcase
      end
   end

   // advance the input register when the result register is free or drains
   assign s1_adv     = !rsp_valid_ff || rsp_tready;
   assign s1_fire    = s1_valid_ff && s1_adv;
   assign req_tready = !s1_valid_ff || s1_adv;
   assign s1_valid_in = (req_tvalid && req_tready) ? 1'b1 : (s1_valid_ff && !s1_adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_new_ff   <= req_tdata[PIXEL_BITS-1:0];
         s1_old_ff   <= req_tdata[REQ_DATA_BITS-1:PIXEL_BITS];
         s1_first_ff <= req_tuser;
      end
   end

   // mark dirty tile, detect line/tile/band/frame ends, build next state
   always_comb begin
      // first pixel of a frame starts from cleared state
      cur_col   = s1_first_ff ? '0 : column_pos_ff;
      cur_cit   = s1_first_ff ? '0 : column_in_tile_ff;
      cur_tc    = s1_first_ff ? '0 : tile_column_ff;
      cur_line  = s1_first_ff ? '0 : line_pos_ff;
      cur_lit   = s1_first_ff ? '0 : line_in_tile_ff;
      cur_bc    = s1_first_ff ? '0 : band_count_ff;
      cur_bm    = s1_first_ff ? '0 : band_bitmap_ff;
      cur_total = s1_first_ff ? '0 : dirty_total_ff;

      band_ok   = cur_bc < tcount_type'(MAX_TILES);
      pix_dirty = (s1_new_ff != s1_old_ff) && (cur_tc < tcount_type'(MAX_TILES)) && band_ok;
      bit_mask  = bitmap_type'(1) << cur_tc;
      upd_bm    = pix_dirty ? (cur_bm | bit_mask) : cur_bm;
      upd_total = (pix_dirty && ((cur_bm & bit_mask) == '0)) ?
                  total_type'(cur_total + 1'b1) : cur_total;

      last_col     = ({1'b0, cur_col} + 1'b1) >= at_least_one(frame_width_ff);
      last_line    = ({1'b0, cur_line} + 1'b1) >= at_least_one(frame_height_ff);
      tile_col_end = ({1'b0, cur_cit} + 1'b1) >= at_least_one(tile_width_ff);
      band_end     = (({1'b0, cur_lit} + 1'b1) >= at_least_one(tile_height_ff)) || last_line;

      emit = last_col && band_end && (band_ok || last_line);
      emit_data = {upd_total,
                   (band_ok ? upd_bm : bitmap_type'(0)),
                   (band_ok ? BAND_BITS'(cur_bc) : BAND_BITS'(MAX_TILES - 1))};

      // hold by default, then step the counters
      column_pos_in     = cur_col;
      column_in_tile_in = cur_cit;
      tile_column_in    = cur_tc;
      line_pos_in       = cur_line;
      line_in_tile_in   = cur_lit;
      band_count_in     = cur_bc;
      band_bitmap_in    = upd_bm;
      dirty_total_in    = upd_total;

      if (last_col) begin
         column_pos_in     = '0;
         column_in_tile_in = '0;
         tile_column_in    = '0;
         if (last_line) begin
            line_pos_in     = '0;
            line_in_tile_in = '0;
            band_count_in   = '0;
            band_bitmap_in  = '0;
            dirty_total_in  = '0;
         end else begin
            line_pos_in = coord_type'(cur_line + 1'b1);
            if (band_end) begin
               band_bitmap_in  = '0;
               line_in_tile_in = '0;
               if (band_ok) begin
                  band_count_in = tcount_type'(cur_bc + 1'b1);
               end
            end else begin
               line_in_tile_in = coord_type'(cur_lit + 1'b1);
            end
         end
      end else begin
         column_pos_in = coord_type'(cur_col + 1'b1);
         if (tile_col_end) begin
            column_in_tile_in = '0;
            if (cur_tc < tcount_type'(MAX_TILES)) begin
               tile_column_in = tcount_type'(cur_tc + 1'b1);
            end
         end else begin
            column_in_tile_in = coord_type'(cur_cit + 1'b1);
         end
      end
   end

   // commit frame state on each processed pixel
   always_ff @(posedge clock) begin
      if (reset) begin
         column_pos_ff     <= '0;
         column_in_tile_ff <= '0;
         tile_column_ff    <= '0;
         line_pos_ff       <= '0;
         line_in_tile_ff   <= '0;
         band_count_ff     <= '0;
         band_bitmap_ff    <= '0;
         dirty_total_ff    <= '0;
      end else if (s1_fire) begin
         column_pos_ff     <= column_pos_in;
         column_in_tile_ff <= column_in_tile_in;
         tile_column_ff    <= tile_column_in;
         line_pos_ff       <= line_pos_in;
         line_in_tile_ff   <= line_in_tile_in;
         band_count_ff     <= band_count_in;
         band_bitmap_ff    <= band_bitmap_in;
         dirty_total_ff    <= dirty_total_in;
      end
   end

   // result register: load on a band end, drop after transfer
   assign rsp_valid_in = s1_fire ? emit : (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && emit) begin
         rsp_data_ff <= emit_data;
         rsp_last_ff <= last_line;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // terms for the checks below
   assign band_past_limit = band_count_ff >= tcount_type'(MAX_TILES);
   assign emit_fire       = s1_fire && emit;
   assign frame_end_fire  = emit_fire && last_line;
   assign frame_cleared   = (line_pos_ff == '0) && (band_count_ff == '0) &&
                            (dirty_total_ff == '0);

   // tile column counter saturates at the tile limit
   `DTD_ASSERT_SAME(a_tile_col_sat, clock, reset, 1'b1, tile_column_ff <= tcount_type'(MAX_TILES))
   // bands past the limit never carry dirty bits
   `DTD_ASSERT_SAME(a_band_bitmap_empty, clock, reset, band_past_limit, band_bitmap_ff == '0)
   // a frame-end result leaves the frame state cleared
   `DTD_ASSERT_NEXT(a_frame_end_clear, clock, reset, frame_end_fire, frame_cleared)
   // a processed band end that emits always presents a result
   `DTD_ASSERT_NEXT(a_emit_valid, clock, reset, emit_fire, rsp_valid_ff)

endmodule
